[rtl/bis_pkg.sv]
// Shared types, constants and helpers for the bilinear image sampler.
package bis_pkg;

   // Default geometry and fixed point format
   localparam int STORE_WIDTH_DEF  = 256;
   localparam int STORE_HEIGHT_DEF = 256;
   localparam int FRAC_BITS_DEF    = 8;

   // Fixed field widths
   localparam int QUERY_W   = 20;
   localparam int PIX_W     = 16;
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 4;
   localparam int NUM_BANKS = 4;

   // Item commands
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_X  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_Y  = 4'd3;

   // Register reset values
   localparam logic signed [CFG_W-1:0] ORIGIN_RST = 12'sd0;
   localparam logic signed [CFG_W-1:0] LIMIT_RST  = 12'sd255;

   // Banks by {row parity, column parity}
   localparam logic [1:0] BANK_EE = 2'd0;
   localparam logic [1:0] BANK_EO = 2'd1;
   localparam logic [1:0] BANK_OE = 2'd2;
   localparam logic [1:0] BANK_OO = 2'd3;

   typedef struct packed {
      logic                      command;
      logic [7:0]                write_col;
      logic [7:0]                write_row;
      logic [PIX_W-1:0]          write_value;
      logic signed [QUERY_W-1:0] query_x;
      logic signed [QUERY_W-1:0] query_y;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] sample_value;
      logic             inside_res;
   } rsp_type;

   // Sample control that travels with the bank read data
   typedef struct packed {
      logic valid;
      logic in_window;
      logic x_odd;
      logic y_odd;
   } ctl_type;

   // Address bits of one half of a dimension (at least one)
   function automatic int half_bits(input int n);
      int h;
      h = $clog2((n + 1) / 2);
      return (h < 1) ? 1 : h;
   endfunction

endpackage

[rtl/bilinear_image_sampler_top.sv]
// Top level of the bilinear image sampler: registers, front end, store and blend.
//
//   channel   ports                            direction   beat taken when
//   request   start, busy, req_data            in          start && !busy
//   response  rsp_valid, rsp_data              out         rsp_valid (one cycle)
//   csr       csr_we, csr_index, csr_wdata     in          csr_we
//
// One item per cycle, writes and samples mixed freely; busy stays low.
// A sample result passes in order through the input register, the registered
// bank read, the horizontal products, the row sums, the vertical products and
// the output register.
// All four neighbors come from the four row/column parity banks in one read.
// Synchronous reset clears the pipeline valids and the registers; the
// store is not cleared. Results cannot be stalled.
module bilinear_image_sampler_top import bis_pkg::*; #(
   parameter int STORE_WIDTH  = STORE_WIDTH_DEF,
   parameter int STORE_HEIGHT = STORE_HEIGHT_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int AW = half_bits(STORE_WIDTH) + half_bits(STORE_HEIGHT);

   logic signed [CFG_W-1:0] origin_x_ff, origin_y_ff, limit_x_ff, limit_y_ff;
   logic signed [CFG_W-1:0] origin_x_in, origin_y_in, limit_x_in, limit_y_in;
   logic                    accept;
   logic                    wr_en;
   logic [1:0]              wr_bank;
   logic [AW-1:0]           wr_addr;
   logic [PIX_W-1:0]        wr_data;
   logic [NUM_BANKS-1:0][AW-1:0]    rd_addr;
   logic [NUM_BANKS-1:0][PIX_W-1:0] rd_data;
   ctl_type                 ctl;
   logic [FRAC_BITS-1:0]    u, v;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Register writes; unknown indexes drop
   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      limit_x_in  = limit_x_ff;
      limit_y_in  = limit_y_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ORIGIN_X: origin_x_in = csr_wdata;
            REG_ORIGIN_Y: origin_y_in = csr_wdata;
            REG_LIMIT_X:  limit_x_in  = csr_wdata;
            REG_LIMIT_Y:  limit_y_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= ORIGIN_RST;
         origin_y_ff <= ORIGIN_RST;
         limit_x_ff  <= LIMIT_RST;
         limit_y_ff  <= LIMIT_RST;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         limit_x_ff  <= limit_x_in;
         limit_y_ff  <= limit_y_in;
      end
   end

   bis_addr #(
      .STORE_WIDTH  (STORE_WIDTH),
      .STORE_HEIGHT (STORE_HEIGHT),
      .FRAC_BITS    (FRAC_BITS)
   ) u_addr (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .origin_x (origin_x_ff),
      .origin_y (origin_y_ff),
      .limit_x  (limit_x_ff),
      .limit_y  (limit_y_ff),
      .wr_en    (wr_en),
      .wr_bank  (wr_bank),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .ctl_ff   (ctl),
      .u_ff     (u),
      .v_ff     (v)
   );

   bis_store #(
      .STORE_WIDTH  (STORE_WIDTH),
      .STORE_HEIGHT (STORE_HEIGHT)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_bank (wr_bank),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bis_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .u         (u),
      .v         (v),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_one_result_per_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy && !reset && (req_data.command == CMD_SAMPLE), 6))
      else $error("response beat does not match an accepted sample");

   a_outside_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.inside_res) |-> (rsp_data.sample_value == '0))
      else $error("outside sample carries a nonzero value");

endmodule

[rtl/bis_addr.sv]
// Coordinate front end: window check, neighbor addresses and write routing.
module bis_addr import bis_pkg::*; #(
   parameter int STORE_WIDTH  = STORE_WIDTH_DEF,
   parameter int STORE_HEIGHT = STORE_HEIGHT_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  req_type                 req_data,
   input  logic signed [CFG_W-1:0] origin_x,
   input  logic signed [CFG_W-1:0] origin_y,
   input  logic signed [CFG_W-1:0] limit_x,
   input  logic signed [CFG_W-1:0] limit_y,
   output logic                    wr_en,
   output logic [1:0]              wr_bank,
   output logic [half_bits(STORE_WIDTH)+half_bits(STORE_HEIGHT)-1:0] wr_addr,
   output logic [PIX_W-1:0]        wr_data,
   output logic [NUM_BANKS-1:0][half_bits(STORE_WIDTH)+half_bits(STORE_HEIGHT)-1:0] rd_addr,
   output ctl_type                 ctl_ff,
   output logic [FRAC_BITS-1:0]    u_ff,
   output logic [FRAC_BITS-1:0]    v_ff
);

   localparam int CB = half_bits(STORE_WIDTH);
   localparam int RB = half_bits(STORE_HEIGHT);
   localparam int CW = ((QUERY_W > 13 + FRAC_BITS) ? QUERY_W : 13 + FRAC_BITS) + 2;
   localparam int XW = CW - FRAC_BITS;
   localparam int XB = $clog2(STORE_WIDTH);
   localparam int YB = $clog2(STORE_HEIGHT);

   logic signed [CW-1:0] qx_ext, qy_ext, ox_sh, oy_sh, lx_sh, ly_sh;
   logic signed [CW-1:0] cx_in, cy_in, s1_cx_ff, s1_cy_ff;
   logic signed [12:0]   lx_m1, ly_m1;
   logic                 win_in, s1_win_ff, s1_valid_ff, s1_cmd_ff;
   logic [7:0]           s1_col_ff, s1_row_ff;
   logic [PIX_W-1:0]     s1_val_ff;
   logic [XW-1:0]        x0, y0;
   logic [XB-1:0]        x0n, xp1;
   logic [YB-1:0]        y0n, yp1;
   logic [CB-1:0]        col_even, col_odd;
   logic [RB-1:0]        row_even, row_odd;
   ctl_type              ctl_in;

   // Scale the window bounds to query units
   assign qx_ext = {{(CW-QUERY_W){req_data.query_x[QUERY_W-1]}}, req_data.query_x};
   assign qy_ext = {{(CW-QUERY_W){req_data.query_y[QUERY_W-1]}}, req_data.query_y};
   assign ox_sh  = {{(CW-CFG_W-FRAC_BITS){origin_x[CFG_W-1]}}, origin_x, {FRAC_BITS{1'b0}}};
   assign oy_sh  = {{(CW-CFG_W-FRAC_BITS){origin_y[CFG_W-1]}}, origin_y, {FRAC_BITS{1'b0}}};
   assign lx_m1  = {limit_x[CFG_W-1], limit_x} - 13'sd1;
   assign ly_m1  = {limit_y[CFG_W-1], limit_y} - 13'sd1;
   assign lx_sh  = {{(CW-13-FRAC_BITS){lx_m1[12]}}, lx_m1, {FRAC_BITS{1'b0}}};
   assign ly_sh  = {{(CW-13-FRAC_BITS){ly_m1[12]}}, ly_m1, {FRAC_BITS{1'b0}}};

   // Offset into the store and window test
   assign cx_in  = qx_ext - ox_sh;
   assign cy_in  = qy_ext - oy_sh;
   assign win_in = (qx_ext >= ox_sh) && (qx_ext <= lx_sh) &&
                   (qy_ext >= oy_sh) && (qy_ext <= ly_sh);

   // Stage one: hold the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_win_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s1_win_ff   <= win_in;
      end
      s1_cmd_ff <= req_data.command;
      s1_col_ff <= req_data.write_col;
      s1_row_ff <= req_data.write_row;
      s1_val_ff <= req_data.write_value;
      s1_cx_ff  <= cx_in;
      s1_cy_ff  <= cy_in;
   end

   // Integer corner of the sample point
   assign x0  = s1_cx_ff[CW-1:FRAC_BITS];
   assign y0  = s1_cy_ff[CW-1:FRAC_BITS];
   assign x0n = x0[XB-1:0];
   assign y0n = y0[YB-1:0];
   assign xp1 = x0n + XB'(1);
   assign yp1 = y0n + YB'(1);

   // Even banks take the neighbor whose half index may step past the corner
   assign col_even = CB'(xp1 >> 1);
   assign col_odd  = CB'(x0n >> 1);
   assign row_even = RB'(yp1 >> 1);
   assign row_odd  = RB'(y0n >> 1);

   assign rd_addr[BANK_EE] = {row_even, col_even};
   assign rd_addr[BANK_EO] = {row_even, col_odd};
   assign rd_addr[BANK_OE] = {row_odd,  col_even};
   assign rd_addr[BANK_OO] = {row_odd,  col_odd};

   // Route pixel writes; drop those beyond the store
   assign wr_en   = s1_valid_ff && (s1_cmd_ff == CMD_WRITE) &&
                    ({5'b0, s1_col_ff} < 13'(STORE_WIDTH)) &&
                    ({5'b0, s1_row_ff} < 13'(STORE_HEIGHT));
   assign wr_bank = {s1_row_ff[0], s1_col_ff[0]};
   assign wr_addr = {RB'(s1_row_ff[7:1]), CB'(s1_col_ff[7:1])};
   assign wr_data = s1_val_ff;

   // Sample control for the blend pipeline
   always_comb begin
      ctl_in.valid     = s1_valid_ff && (s1_cmd_ff == CMD_SAMPLE);
      ctl_in.in_window = s1_win_ff && (x0 < XW'(STORE_WIDTH - 1)) &&
                         (y0 < XW'(STORE_HEIGHT - 1));
      ctl_in.x_odd     = x0[0];
      ctl_in.y_odd     = y0[0];
   end

   // Stage two: aligned with the bank read data
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      u_ff <= s1_cx_ff[FRAC_BITS-1:0];
      v_ff <= s1_cy_ff[FRAC_BITS-1:0];
   end

   a_inside_needs_window: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.in_window |-> $past(s1_win_ff))
      else $error("inside flag set without a window hit");

endmodule

[rtl/bis_store.sv]
// Image store: four parity banks, one write and four reads per cycle.
module bis_store import bis_pkg::*; #(
   parameter int STORE_WIDTH  = STORE_WIDTH_DEF,
   parameter int STORE_HEIGHT = STORE_HEIGHT_DEF
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [1:0]              wr_bank,
   input  logic [half_bits(STORE_WIDTH)+half_bits(STORE_HEIGHT)-1:0] wr_addr,
   input  logic [PIX_W-1:0]        wr_data,
   input  logic [NUM_BANKS-1:0][half_bits(STORE_WIDTH)+half_bits(STORE_HEIGHT)-1:0] rd_addr,
   output logic [NUM_BANKS-1:0][PIX_W-1:0] rd_data
);

   localparam int AW    = half_bits(STORE_WIDTH) + half_bits(STORE_HEIGHT);
   localparam int DEPTH = 2 ** AW;

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [PIX_W-1:0] mem [0:DEPTH-1];
      logic [PIX_W-1:0] rd_ff;

      // Write one pixel, register the read word
      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == 2'(b))) begin
            mem[wr_addr] <= wr_data;
         end
         rd_ff <= mem[rd_addr[b]];
      end

      assign rd_data[b] = rd_ff;
   end

endmodule

[rtl/bis_blend.sv]
// Bilinear blend pipeline: horizontal weights, then vertical, then truncate.
module bis_blend import bis_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctl_type                        ctl,
   input  logic [FRAC_BITS-1:0]           u,
   input  logic [FRAC_BITS-1:0]           v,
   input  logic [NUM_BANKS-1:0][PIX_W-1:0] rd_data,
   output logic                           rsp_valid,
   output rsp_type                        rsp_data
);

   localparam int PW = PIX_W + FRAC_BITS + 1;
   localparam int GW = PIX_W + FRAC_BITS;
   localparam int NW = PIX_W + 2 * FRAC_BITS + 1;
   localparam int SW = PIX_W + 2 * FRAC_BITS;
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   logic [PIX_W-1:0]     p00, p01, p10, p11;
   logic [FRAC_BITS:0]   wu, wv;
   logic [PW-1:0]        m00_ff, m01_ff, m10_ff, m11_ff;
   logic [GW-1:0]        gm_in, gn_in, gm_ff, gn_ff;
   logic [NW-1:0]        n0_ff, n1_ff;
   logic [SW-1:0]        sum_in;
   logic [FRAC_BITS-1:0] v3_ff, v4_ff;
   logic                 vld3_ff, vld4_ff, vld5_ff, ins3_ff, ins4_ff, ins5_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_in, rsp_ff;

   // Pick the four neighbors out of the parity banks
   assign p00 = rd_data[{ctl.y_odd,  ctl.x_odd}];
   assign p01 = rd_data[{ctl.y_odd, ~ctl.x_odd}];
   assign p10 = rd_data[{~ctl.y_odd,  ctl.x_odd}];
   assign p11 = rd_data[{~ctl.y_odd, ~ctl.x_odd}];
   assign wu  = ONE - {1'b0, u};

   // Horizontal products
   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
         ins3_ff <= 1'b0;
      end else begin
         vld3_ff <= ctl.valid;
         ins3_ff <= ctl.in_window;
      end
      m00_ff <= PW'(wu) * PW'(p00);
      m01_ff <= PW'(u) * PW'(p01);
      m10_ff <= PW'(wu) * PW'(p10);
      m11_ff <= PW'(u) * PW'(p11);
      v3_ff  <= v;
   end

   // Row sums
   assign gm_in = GW'(m00_ff + m01_ff);
   assign gn_in = GW'(m10_ff + m11_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
         ins4_ff <= 1'b0;
      end else begin
         vld4_ff <= vld3_ff;
         ins4_ff <= ins3_ff;
      end
      gm_ff <= gm_in;
      gn_ff <= gn_in;
      v4_ff <= v3_ff;
   end

   // Vertical products
   assign wv = ONE - {1'b0, v4_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
         ins5_ff <= 1'b0;
      end else begin
         vld5_ff <= vld4_ff;
         ins5_ff <= ins4_ff;
      end
      n0_ff <= NW'(wv) * NW'(gm_ff);
      n1_ff <= NW'(v4_ff) * NW'(gn_ff);
   end

   // Final sum, truncate to Q16.0, zero outside the window
   assign sum_in = SW'(n0_ff + n1_ff);

   always_comb begin
      rsp_in.inside_res   = ins5_ff;
      rsp_in.sample_value = ins5_ff ? sum_in[SW-1:2*FRAC_BITS] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld5_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
